FILE: hw/rtl/best_fit_partition_allocator_assert.svh
// Assertion macros for the partition allocator
`ifndef BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BFPA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BFPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BFPA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BFPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/bfpa_pkg.sv
`timescale 1ns / 1ps
package bfpa_pkg;

   localparam int NUM_PARTITIONS = 256;
   localparam int IDX_W = $clog2(NUM_PARTITIONS);
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam int SIZE_W = 40;
   localparam int TAG_W = 31;
   localparam int REQ_W = 31;
   localparam int PAGE_W = 20;
   localparam int PADDR_W = 3;

   localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
   localparam logic [PAGE_W-1:0] PAGE_RESET = 20'd4096;
   localparam logic [PADDR_W-1:0] ADDR_PAGE_BYTES = 3'd0;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   typedef struct packed {
      logic [31:0] owner;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] base;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_DECIDE,
      S_DIV,
      S_GROW,
      S_SHIFT,
      S_INS,
      S_FREE,
      S_FEND,
      S_LARG,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/best_fit_partition_allocator.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake           | Payload
// request   | in        | req_valid/req_stall | req_command, req_owner_tag, req_request_size
// response  | out       | rsp_valid/rsp_stall | rsp_largest_free, rsp_pages_total, rsp_table_full
// config    | in        | psel/penable/pready | paddr, pwdata, prdata (page_bytes)
//
// One request at a time; the table lives in one single-port-read memory, one entry a cycle.
// Allocate with a fit: table scan, shift of the entries above the fit and insert (only when
// a free remainder is left), largest-free scan. Allocate by growing: table scan, page
// divider, up to two inserts, largest-free scan. Free: compaction pass, final write,
// largest-free scan.
// Synchronous reset gives one free entry of size zero; no clearing pass.
// A waiting response does not block the next request; a result that finds the output
// register still held waits for it to drain.
`include "best_fit_partition_allocator_assert.svh"

module best_fit_partition_allocator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_command,
   input  logic [bfpa_pkg::TAG_W-1:0] req_owner_tag,
   input  logic [bfpa_pkg::REQ_W-1:0] req_request_size,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [bfpa_pkg::SIZE_W-1:0] rsp_largest_free,
   output logic [bfpa_pkg::SIZE_W-1:0] rsp_pages_total,
   output logic rsp_table_full,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [bfpa_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   localparam int IW = bfpa_pkg::IDX_W;
   localparam int CW = bfpa_pkg::CNT_W;
   localparam int SW = bfpa_pkg::SIZE_W;
   localparam int PW = bfpa_pkg::PAGE_W;
   localparam int RW = bfpa_pkg::REQ_W;
   localparam logic [CW-1:0] NUM_CNT = CW'(bfpa_pkg::NUM_PARTITIONS);

   bfpa_pkg::entry_type mem [bfpa_pkg::NUM_PARTITIONS];
   bfpa_pkg::entry_type rdata_ff, rd_entry, mem_wd;
   logic [IW-1:0] rd_addr, mem_wa;
   logic mem_we;
   logic rz_ff, init0_ff, init0_in;

   bfpa_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] pages_ff, pages_in;
   logic [PW-1:0] page_ff;
   logic cmd_ff, cmd_in;
   logic [bfpa_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic [RW-1:0] req_ff, req_in;
   logic [CW-1:0] ri_ff, ri_in;
   logic dv_ff, dv_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   bfpa_pkg::entry_type best_ff, best_in, last_ff, last_in;
   bfpa_pkg::entry_type new_ff, new_in, sec_ff, sec_in, pend_ff, pend_in;
   logic second_ff, second_in;
   logic [CW-1:0] ins_ff, ins_in, sh_ff, sh_in, w_ff, w_in;
   logic wp_ff, wp_in;
   logic [IW-1:0] wa_ff, wa_in;
   logic [RW-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [PW-1:0] rmd_ff, rmd_in;
   logic [4:0] dcnt_ff, dcnt_in;
   logic pv_ff, pv_in;
   logic [SW-1:0] big_ff, big_in;
   logic full_ff, full_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_big_ff, rsp_big_in, rsp_pages_ff, rsp_pages_in;
   logic rsp_full_ff, rsp_full_in;

   logic [PW-1:0] pg;
   logic [SW-1:0] req40;
   logic [SW-1:0] rem40;
   logic [PW:0] div_t;
   logic [PW-1:0] remb;
   logic [31:0] pages32;
   logic [SW:0] psum;
   logic [SW-1:0] grow_base;
   logic [31:0] d_owner;
   logic scan_done;
   logic cfg_wr;

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & (paddr == bfpa_pkg::ADDR_PAGE_BYTES);
   assign prdata = (paddr == bfpa_pkg::ADDR_PAGE_BYTES) ? {{(32-PW){1'b0}}, page_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= bfpa_pkg::PAGE_RESET;
      end else if (cfg_wr) begin
         page_ff <= pwdata[PW-1:0];
      end
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[rd_addr];
      rz_ff <= (rd_addr == '0) & ~init0_ff;
   end

   // entry 0 reads as free, empty, until first written
   assign rd_entry = rz_ff ? '{owner: bfpa_pkg::FREE_MARK, size: '0, base: '0} : rdata_ff;

   assign pg = (page_ff == '0) ? PW'(1) : page_ff;
   assign req40 = {{(SW-RW){1'b0}}, req_ff};
   assign rem40 = best_ff.size - req40;
   assign div_t = {rmd_ff, dvd_ff[RW-1]};
   assign remb = (rmd_ff != '0) ? (pg - rmd_ff) : '0;
   assign pages32 = {1'b0, quo_ff} + {31'd0, (rmd_ff != '0)};
   assign psum = {1'b0, pages_ff} + {{(SW+1-32){1'b0}}, pages32};
   assign grow_base = last_ff.base + last_ff.size;
   assign d_owner = (rd_entry.owner == {1'b0, tag_ff}) ? bfpa_pkg::FREE_MARK : rd_entry.owner;
   assign scan_done = (ri_ff == count_ff) & ~dv_ff;

   assign req_stall = (state_ff != bfpa_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_largest_free = rsp_big_ff;
   assign rsp_pages_total = rsp_pages_ff;
   assign rsp_table_full = rsp_full_ff;

   // sequencer: next state and memory access
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pages_in = pages_ff;
      cmd_in = cmd_ff;
      tag_in = tag_ff;
      req_in = req_ff;
      ri_in = ri_ff;
      dv_in = 1'b0;
      idx_in = idx_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_in = best_ff;
      last_in = last_ff;
      new_in = new_ff;
      sec_in = sec_ff;
      pend_in = pend_ff;
      second_in = second_ff;
      ins_in = ins_ff;
      sh_in = sh_ff;
      w_in = w_ff;
      wp_in = 1'b0;
      wa_in = wa_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rmd_in = rmd_ff;
      dcnt_in = dcnt_ff;
      pv_in = pv_ff;
      big_in = big_ff;
      full_in = full_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_big_in = rsp_big_ff;
      rsp_pages_in = rsp_pages_ff;
      rsp_full_in = rsp_full_ff;
      init0_in = init0_ff;
      rd_addr = ri_ff[IW-1:0];
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = new_ff;

      // sequential read of the table for the scanning states
      if (state_ff == bfpa_pkg::S_FIND || state_ff == bfpa_pkg::S_FREE ||
          state_ff == bfpa_pkg::S_LARG) begin
         if (ri_ff != count_ff) begin
            ri_in = ri_ff + CW'(1);
            dv_in = 1'b1;
            idx_in = ri_ff[IW-1:0];
         end
      end

      unique case (state_ff)
         bfpa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               tag_in = req_owner_tag;
               req_in = req_request_size;
               full_in = 1'b0;
               ri_in = '0;
               found_in = 1'b0;
               pv_in = 1'b0;
               w_in = '0;
               second_in = 1'b0;
               state_in = (req_command == bfpa_pkg::CMD_FREE) ? bfpa_pkg::S_FREE
                                                              : bfpa_pkg::S_FIND;
            end
         end
         bfpa_pkg::S_FIND: begin
            // track best fit and the last entry
            if (dv_ff) begin
               if (rd_entry.owner == bfpa_pkg::FREE_MARK && rd_entry.size >= req40 &&
                   (!found_ff || rd_entry.size < best_ff.size)) begin
                  best_in = rd_entry;
                  best_idx_in = idx_ff;
                  found_in = 1'b1;
               end
               if (idx_ff == IW'(count_ff - CW'(1))) begin
                  last_in = rd_entry;
               end
            end
            if (scan_done) begin
               state_in = bfpa_pkg::S_DECIDE;
            end
         end
         bfpa_pkg::S_DECIDE: begin
            if (found_ff) begin
               if (rem40 != '0 && count_ff >= NUM_CNT) begin
                  full_in = 1'b1;
                  ri_in = '0;
                  big_in = '0;
                  state_in = bfpa_pkg::S_LARG;
               end else begin
                  mem_we = 1'b1;
                  mem_wa = best_idx_ff;
                  mem_wd = '{owner: {1'b0, tag_ff}, size: req40, base: best_ff.base};
                  if (rem40 != '0) begin
                     new_in = '{owner: bfpa_pkg::FREE_MARK, size: rem40,
                                base: best_ff.base + req40};
                     ins_in = {1'b0, best_idx_ff} + CW'(1);
                     sh_in = count_ff;
                     state_in = bfpa_pkg::S_SHIFT;
                  end else begin
                     ri_in = '0;
                     big_in = '0;
                     state_in = bfpa_pkg::S_LARG;
                  end
               end
            end else begin
               dvd_in = (last_ff.owner == bfpa_pkg::FREE_MARK)
                        ? RW'(req40 - last_ff.size) : req_ff;
               quo_in = '0;
               rmd_in = '0;
               dcnt_in = 5'(RW - 1);
               state_in = bfpa_pkg::S_DIV;
            end
         end
         bfpa_pkg::S_DIV: begin
            // one quotient bit a cycle
            if (div_t >= {1'b0, pg}) begin
               rmd_in = PW'(div_t - {1'b0, pg});
               quo_in = {quo_ff[RW-2:0], 1'b1};
            end else begin
               rmd_in = div_t[PW-1:0];
               quo_in = {quo_ff[RW-2:0], 1'b0};
            end
            dvd_in = {dvd_ff[RW-2:0], 1'b0};
            dcnt_in = dcnt_ff - 5'd1;
            if (dcnt_ff == '0) begin
               state_in = bfpa_pkg::S_GROW;
            end
         end
         bfpa_pkg::S_GROW: begin
            ri_in = '0;
            big_in = '0;
            if (last_ff.owner == bfpa_pkg::FREE_MARK) begin
               if (remb != '0 && count_ff >= NUM_CNT) begin
                  full_in = 1'b1;
                  state_in = bfpa_pkg::S_LARG;
               end else begin
                  mem_we = 1'b1;
                  mem_wa = IW'(count_ff - CW'(1));
                  mem_wd = '{owner: {1'b0, tag_ff}, size: req40, base: last_ff.base};
                  pages_in = psum[SW] ? {SW{1'b1}} : psum[SW-1:0];
                  if (remb != '0) begin
                     new_in = '{owner: bfpa_pkg::FREE_MARK, size: SW'(remb),
                                base: last_ff.base + req40};
                     ins_in = count_ff;
                     sh_in = count_ff;
                     state_in = bfpa_pkg::S_SHIFT;
                  end else begin
                     state_in = bfpa_pkg::S_LARG;
                  end
               end
            end else if ({1'b0, count_ff} + ((remb != '0) ? (CW+1)'(2) : (CW+1)'(1)) >
                         {1'b0, NUM_CNT}) begin
               full_in = 1'b1;
               state_in = bfpa_pkg::S_LARG;
            end else begin
               pages_in = psum[SW] ? {SW{1'b1}} : psum[SW-1:0];
               new_in = '{owner: {1'b0, tag_ff}, size: req40, base: grow_base};
               sec_in = '{owner: bfpa_pkg::FREE_MARK, size: SW'(remb),
                          base: grow_base + req40};
               second_in = (remb != '0);
               ins_in = count_ff;
               sh_in = count_ff;
               state_in = bfpa_pkg::S_SHIFT;
            end
         end
         bfpa_pkg::S_SHIFT: begin
            // move entries up by one, top first
            if (wp_ff) begin
               mem_we = 1'b1;
               mem_wa = wa_ff;
               mem_wd = rd_entry;
               if (wa_ff == '0) begin
                  init0_in = 1'b1;
               end
            end
            if (sh_ff != ins_ff) begin
               rd_addr = IW'(sh_ff - CW'(1));
               wp_in = 1'b1;
               wa_in = sh_ff[IW-1:0];
               sh_in = sh_ff - CW'(1);
            end else if (!wp_ff) begin
               state_in = bfpa_pkg::S_INS;
            end
         end
         bfpa_pkg::S_INS: begin
            mem_we = 1'b1;
            mem_wa = ins_ff[IW-1:0];
            mem_wd = new_ff;
            count_in = count_ff + CW'(1);
            if (second_ff) begin
               second_in = 1'b0;
               new_in = sec_ff;
               ins_in = ins_ff + CW'(1);
            end else begin
               ri_in = '0;
               big_in = '0;
               state_in = bfpa_pkg::S_LARG;
            end
         end
         bfpa_pkg::S_FREE: begin
            // release the tag and merge runs of free entries
            if (dv_ff) begin
               if (pv_ff && pend_ff.owner == bfpa_pkg::FREE_MARK &&
                   d_owner == bfpa_pkg::FREE_MARK) begin
                  pend_in.size = pend_ff.size + rd_entry.size;
               end else begin
                  if (pv_ff) begin
                     mem_we = 1'b1;
                     mem_wa = w_ff[IW-1:0];
                     mem_wd = pend_ff;
                     w_in = w_ff + CW'(1);
                  end
                  pend_in = '{owner: d_owner, size: rd_entry.size, base: rd_entry.base};
                  pv_in = 1'b1;
               end
            end
            if (scan_done) begin
               state_in = bfpa_pkg::S_FEND;
            end
         end
         bfpa_pkg::S_FEND: begin
            mem_we = 1'b1;
            mem_wa = w_ff[IW-1:0];
            mem_wd = pend_ff;
            count_in = w_ff + CW'(1);
            ri_in = '0;
            big_in = '0;
            state_in = bfpa_pkg::S_LARG;
         end
         bfpa_pkg::S_LARG: begin
            if (dv_ff && rd_entry.owner == bfpa_pkg::FREE_MARK && rd_entry.size > big_ff) begin
               big_in = rd_entry.size;
            end
            if (scan_done) begin
               state_in = bfpa_pkg::S_DONE;
            end
         end
         bfpa_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_big_in = big_ff;
               rsp_pages_in = pages_ff;
               rsp_full_in = full_ff;
               state_in = bfpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bfpa_pkg::S_IDLE;
         end
      endcase

      if (mem_we && mem_wa == '0) begin
         init0_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfpa_pkg::S_IDLE;
         count_ff <= CW'(1);
         pages_ff <= '0;
         init0_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dv_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pages_ff <= pages_in;
         init0_ff <= init0_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff <= dv_in;
         wp_ff <= wp_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      tag_ff <= tag_in;
      req_ff <= req_in;
      ri_ff <= ri_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      best_idx_ff <= best_idx_in;
      best_ff <= best_in;
      last_ff <= last_in;
      new_ff <= new_in;
      sec_ff <= sec_in;
      pend_ff <= pend_in;
      second_ff <= second_in;
      ins_ff <= ins_in;
      sh_ff <= sh_in;
      w_ff <= w_in;
      wa_ff <= wa_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rmd_ff <= rmd_in;
      dcnt_ff <= dcnt_in;
      pv_ff <= pv_in;
      big_ff <= big_in;
      full_ff <= full_in;
      rsp_big_ff <= rsp_big_in;
      rsp_pages_ff <= rsp_pages_in;
      rsp_full_ff <= rsp_full_in;
   end

   `BFPA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff != '0 && count_ff <= NUM_CNT)
   `BFPA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `BFPA_ASSERT_IMP(a_full_alloc_only, clock, reset, state_ff == bfpa_pkg::S_DONE && full_ff, cmd_ff == bfpa_pkg::CMD_ALLOC)
   `BFPA_ASSERT_NEXT(a_full_keeps_count, clock, reset, state_ff == bfpa_pkg::S_LARG && full_ff, $stable(count_ff))

endmodule
